// ===== rtl/core/bvc_pkg.sv =====
// ----------------------------------------------------------------------------
// bvc_pkg
// Shared types and constants for the search tree validity checker: the
// payload words, the slot record, the controller states and the command and
// status groups between controller and datapath.
// ----------------------------------------------------------------------------
package bvc_pkg;

    // Field widths fixed by the word formats.
    localparam int KEY_W    = 64;
    localparam int PARENT_W = 10;
    localparam int NODES_W  = 11;

    // Root bounds and the saturation floor of a left child's upper bound.
    localparam logic signed [KEY_W-1:0] KEY_LIMIT = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [KEY_W-1:0] KEY_FLOOR = 64'sh8000_0000_0000_0000;

    // Side codes.
    localparam logic SIDE_LEFT  = 1'b0;
    localparam logic SIDE_RIGHT = 1'b1;

    // Input word.
    typedef struct packed {
        logic signed [KEY_W-1:0] node_value;
        logic [PARENT_W-1:0]     parent_slot;
        logic                    child_side;
        logic                    is_root;
        logic                    is_last;
    } t_in_word;

    // Output word.
    typedef struct packed {
        logic               tree_is_search_tree;
        logic [NODES_W-1:0] nodes_seen;
    } t_out_word;

    // One stored node: its key and its two bounds.
    typedef struct packed {
        logic signed [KEY_W-1:0] value;
        logic signed [KEY_W-1:0] lower;
        logic signed [KEY_W-1:0] upper;
    } t_slot;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_ADDR,
        S_CHECK
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic step;
        logic read;
        logic commit;
    } t_ctrl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_root;
        logic is_last;
        logic mod_done;
        logic out_blocked;
    } t_ctrl_status;

endpackage

// ===== rtl/core/bvc_if.sv =====
// ----------------------------------------------------------------------------
// bvc_if
// Valid/ready channels of the checker: one for the node words coming in and
// one for the verdict words going out.
// ----------------------------------------------------------------------------
interface bvc_in_if;
    logic              valid;
    logic              ready;
    bvc_pkg::t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface bvc_out_if;
    logic               valid;
    logic               ready;
    bvc_pkg::t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/bst_validity_checker.sv =====
// ----------------------------------------------------------------------------
// bst_validity_checker
// Checks node by node whether a binary tree is a valid search tree.
//
// Words arrive on i_in, one node each: the root first, then children that
// name an earlier parent slot and a side. Each node is checked against the
// bounds inherited from its parent and stored with them in the slot memory.
// On the node marked last, one verdict word leaves on o_out with the
// validity flag and the node count.
// Each node takes three steps: the word is taken, the parent slot is read
// from the single read port of the slot memory, then the bounds are derived
// and checked and the node written back. When the table depth is below 1024
// and not a power of two, the parent index is first reduced modulo the depth
// by a reciprocal multiplication, adding a step to every non-root node.
// The verdict is loaded into the output register by the commit of the last
// node. A new node is taken while a verdict waits; if the receiver stalls, a
// further last node holds in its check until the verdict is taken.
// Reset returns the controller to idle, empties the output register, clears
// the node count and sets the validity flag; the slot memory is not cleared.
// ----------------------------------------------------------------------------
module bst_validity_checker #(
    parameter int MAX_NODES = 1024
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    bvc_in_if.sink         i_in,
    bvc_out_if.source      o_out
);

    bvc_pkg::t_ctrl_cmd    ctrl_cmd;
    bvc_pkg::t_ctrl_status ctrl_status;

    // Sequencer.
    bvc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (ctrl_status),
        .o_cmd      (ctrl_cmd)
    );

    // Check datapath with the slot memory.
    bvc_dp #(
        .MAX_NODES (MAX_NODES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (ctrl_cmd),
        .o_status    (ctrl_status),
        .i_in_data   (i_in.data),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_out_data  (o_out.data)
    );

endmodule

// ===== rtl/core/bvc_ram.sv =====
// ----------------------------------------------------------------------------
// bvc_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds its data until the next read.
// ----------------------------------------------------------------------------
module bvc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/bvc_ctrl.sv =====
// ----------------------------------------------------------------------------
// bvc_ctrl
// Controller of the checker: takes a word, waits for the parent address to
// settle, reads the parent slot and commits the check.
// ----------------------------------------------------------------------------
module bvc_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  bvc_pkg::t_ctrl_status i_status,
    output bvc_pkg::t_ctrl_cmd    o_cmd
);

    bvc_pkg::t_state r_state;
    bvc_pkg::t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bvc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bvc_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = bvc_pkg::S_ADDR;
                end
            end
            bvc_pkg::S_ADDR: begin
                if (i_status.is_root || i_status.mod_done) begin
                    n_state = bvc_pkg::S_CHECK;
                end
            end
            bvc_pkg::S_CHECK: begin
                if (!(i_status.is_last && i_status.out_blocked)) begin
                    n_state = bvc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bvc_pkg::S_IDLE;
            end
        endcase
    end

    // Commands.
    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            bvc_pkg::S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            bvc_pkg::S_ADDR: begin
                if (i_status.is_root || i_status.mod_done) begin
                    o_cmd.read = 1'b1;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            bvc_pkg::S_CHECK: begin
                // A verdict waits while the previous one has not been taken.
                o_cmd.commit = !(i_status.is_last && i_status.out_blocked);
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== rtl/core/bvc_dp.sv =====
// ----------------------------------------------------------------------------
// bvc_dp
// Datapath of the checker: input capture, parent slot address, slot memory,
// bounds derivation and check, node count, sticky flag and output register.
// ----------------------------------------------------------------------------
module bvc_dp #(
    parameter int MAX_NODES = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  bvc_pkg::t_ctrl_cmd    i_cmd,
    output bvc_pkg::t_ctrl_status o_status,
    input  bvc_pkg::t_in_word     i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output bvc_pkg::t_out_word    o_out_data
);

    localparam int AW    = $clog2(MAX_NODES);
    localparam int CW    = $clog2(MAX_NODES + 1);
    localparam int PW    = bvc_pkg::PARENT_W;
    localparam int SLOTW = $bits(bvc_pkg::t_slot);
    localparam bit POW2  = (MAX_NODES & (MAX_NODES - 1)) == 0;
    localparam bit WIDE  = MAX_NODES >= (1 << PW);

    // Captured input word.
    logic signed [bvc_pkg::KEY_W-1:0] r_key;
    logic [PW-1:0]                    r_parent;
    logic                             r_side;
    logic                             r_root;
    logic                             r_last;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_key    <= i_in_data.node_value;
            r_parent <= i_in_data.parent_slot;
            r_side   <= i_in_data.child_side;
            r_root   <= i_in_data.is_root;
            r_last   <= i_in_data.is_last;
        end
    end

    // Parent slot address, reduced modulo the table depth.
    logic [AW-1:0] rd_addr;
    logic          mod_done;

    generate
        if (WIDE) begin : g_addr_wide
            assign rd_addr  = AW'(r_parent);
            assign mod_done = 1'b1;
        end else if (POW2) begin : g_addr_mask
            assign rd_addr  = r_parent[AW-1:0];
            assign mod_done = 1'b1;
        end else begin : g_addr_mod
            // Remainder by reciprocal multiplication: the quotient is
            // registered, and the remainder follows from it combinationally by
            // a constant multiply and a subtract.
            localparam int SH = 2 * PW;
            localparam int MW = PW + SH + 1;
            localparam logic [MW-1:0] RECIP =
                MW'(((64'd1 << SH) + 64'(MAX_NODES) - 64'd1) / 64'(MAX_NODES));

            logic [MW-1:0] prod;
            logic [PW-1:0] r_quot;
            logic          r_qdone;
            logic [PW-1:0] rem_full;

            assign prod     = MW'(r_parent) * RECIP;
            assign rem_full = r_parent - r_quot * PW'(MAX_NODES);

            always_ff @(posedge i_clk) begin
                if (i_cmd.capture) begin
                    r_qdone <= 1'b0;
                end else if (i_cmd.step) begin
                    r_quot  <= prod[SH +: PW];
                    r_qdone <= 1'b1;
                end
            end

            assign rd_addr  = rem_full[AW-1:0];
            assign mod_done = r_qdone;
        end
    endgenerate

    // Slot memory holding key and bounds of every stored node.
    bvc_pkg::t_slot parent_slot;
    bvc_pkg::t_slot wr_slot;
    logic [SLOTW-1:0] rd_data;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;

    bvc_ram #(
        .WIDTH (SLOTW),
        .DEPTH (MAX_NODES)
    ) u_slot_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_slot),
        .i_rd_en   (i_cmd.read),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign parent_slot = bvc_pkg::t_slot'(rd_data);

    // Bounds of this node.
    logic signed [bvc_pkg::KEY_W-1:0] lo;
    logic signed [bvc_pkg::KEY_W-1:0] hi;

    always_comb begin
        if (r_root) begin
            lo = -bvc_pkg::KEY_LIMIT;
            hi = bvc_pkg::KEY_LIMIT;
        end else if (r_side == bvc_pkg::SIDE_RIGHT) begin
            lo = parent_slot.value;
            hi = parent_slot.upper;
        end else begin
            lo = parent_slot.lower;
            if (parent_slot.value == bvc_pkg::KEY_FLOOR) begin
                hi = bvc_pkg::KEY_FLOOR;
            end else begin
                hi = parent_slot.value - 64'sd1;
            end
        end
    end

    // Check, slot allocation and count.
    logic          r_still;
    logic [CW-1:0] r_next;
    logic          valid_now;
    logic [CW-1:0] slot_base;
    logic [CW-1:0] slot_after;
    logic          has_room;

    assign valid_now  = (r_root || r_still) && !(r_key < lo || r_key > hi);
    assign slot_base  = r_root ? '0 : r_next;
    assign has_room   = slot_base < CW'(MAX_NODES);
    assign slot_after = has_room ? slot_base + CW'(1) : slot_base;

    assign wr_en         = i_cmd.commit && has_room;
    assign wr_addr       = slot_base[AW-1:0];
    assign wr_slot.value = r_key;
    assign wr_slot.lower = lo;
    assign wr_slot.upper = hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next  <= '0;
            r_still <= 1'b1;
        end else if (i_cmd.commit) begin
            if (r_last) begin
                r_next  <= '0;
                r_still <= 1'b1;
            end else begin
                r_next  <= slot_after;
                r_still <= valid_now;
            end
        end
    end

    // Output register; a new verdict loads only once the old one has gone.
    logic               r_out_valid;
    bvc_pkg::t_out_word r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit && r_last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && r_last) begin
            r_out_data.tree_is_search_tree <= valid_now;
            r_out_data.nodes_seen          <= bvc_pkg::NODES_W'(slot_after);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Status towards the controller.
    assign o_status.is_root     = r_root;
    assign o_status.is_last     = r_last;
    assign o_status.mod_done    = mod_done;
    assign o_status.out_blocked = r_out_valid && !i_out_ready;

endmodule

// ===== tb/tb_bst_validity_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bst_validity_checker
// Self-checking bench for the search tree validity checker. Node words are
// sent through the input channel with random gaps. A behavioural predictor
// keeps its own slot table and works out each verdict word, and a monitor
// compares every verdict that leaves the block against the oldest expected
// one. Directed trees cover the key extremes, bound saturation, abandoned
// and orphaned trees and stale parents. Random forests, one tree that
// overflows the slot table and a stall-free stretch follow.
// ----------------------------------------------------------------------------
module tb_bst_validity_checker;

    import bvc_pkg::*;

    localparam int TABLE_DEPTH = 1024;
    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE_CYCLES = 20;

    logic i_clk;
    logic i_rst_n;

    bvc_in_if  node_ch ();
    bvc_out_if verdict_ch ();

    bst_validity_checker #(
        .MAX_NODES (TABLE_DEPTH)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (node_ch),
        .o_out   (verdict_ch)
    );

    // Predictor state: a mirror of the slot table and the running tree.
    logic signed [KEY_W-1:0] slot_key [TABLE_DEPTH];
    logic signed [KEY_W-1:0] slot_lo  [TABLE_DEPTH];
    logic signed [KEY_W-1:0] slot_hi  [TABLE_DEPTH];
    int        fill;        // slot for the next node of the open tree
    int        high_water;  // slots below this have been written since reset
    bit        tree_ok;
    t_out_word verdict_q [$];

    // Bench bookkeeping.
    int        errors;
    int        cycles;
    int        nodes_sent;
    int        verdicts_checked;
    int        broken_verdicts;
    bit        calm;
    t_out_word due;

    // Clock.
    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Watchdog.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: watchdog expired with %0d verdicts outstanding",
                     $time, verdict_q.size());
            $display("tb_bst_validity_checker failed");
            $finish;
        end
    end

    // Receiver back-pressure, switched off during calm stretches.
    always @(negedge i_clk) begin
        verdict_ch.ready <= calm || ($urandom_range(99) >= 17);
    end

    // Bounds inherited by a child of slot p on the given side.
    function automatic void child_bounds(input int p, input logic side,
                                         output logic signed [KEY_W-1:0] lo,
                                         output logic signed [KEY_W-1:0] hi);
        if (side == SIDE_RIGHT) begin
            lo = slot_key[p];
            hi = slot_hi[p];
        end else begin
            lo = slot_lo[p];
            hi = (slot_key[p] == KEY_FLOOR) ? KEY_FLOOR : slot_key[p] - 64'sd1;
        end
    endfunction

    // Apply one accepted node word to the predictor and queue any verdict.
    task automatic judge_node(input t_in_word w);
        logic signed [KEY_W-1:0] key;
        logic signed [KEY_W-1:0] lo;
        logic signed [KEY_W-1:0] hi;
        int p;
        key = w.node_value;
        p = int'(w.parent_slot) % TABLE_DEPTH;
        if (w.is_root) begin
            fill = 0;
            tree_ok = 1'b1;
            lo = -KEY_LIMIT;
            hi = KEY_LIMIT;
        end else begin
            child_bounds(p, w.child_side, lo, hi);
        end
        if (key < lo || key > hi) tree_ok = 1'b0;
        // A full table still checks the node but no longer stores it.
        if (fill < TABLE_DEPTH) begin
            slot_key[fill] = key;
            slot_lo[fill] = lo;
            slot_hi[fill] = hi;
            fill++;
            if (fill > high_water) high_water = fill;
        end
        if (w.is_last) begin
            verdict_q.push_back('{tree_is_search_tree: tree_ok,
                                  nodes_seen: NODES_W'(fill)});
            fill = 0;
            tree_ok = 1'b1;
        end
    endtask

    // Verdict monitor.
    always @(posedge i_clk) begin
        if (i_rst_n && verdict_ch.valid && verdict_ch.ready) begin
            if (verdict_q.size() == 0) begin
                $display("%0t: verdict word with none expected: expected nothing, got %p",
                         $time, verdict_ch.data);
                errors++;
            end else begin
                due = verdict_q.pop_front();
                verdicts_checked++;
                if (!due.tree_is_search_tree) broken_verdicts++;
                if (verdict_ch.data.tree_is_search_tree !== due.tree_is_search_tree) begin
                    $display("%0t: tree_is_search_tree mismatch: expected %0b, got %0b",
                             $time, due.tree_is_search_tree,
                             verdict_ch.data.tree_is_search_tree);
                    errors++;
                end
                if (verdict_ch.data.nodes_seen !== due.nodes_seen) begin
                    $display("%0t: nodes_seen mismatch: expected %0d, got %0d",
                             $time, due.nodes_seen, verdict_ch.data.nodes_seen);
                    errors++;
                end
            end
        end
    end

    function automatic t_in_word node_word(input logic signed [KEY_W-1:0] key,
                                           input int parent, input logic side,
                                           input logic root, input logic last);
        t_in_word w;
        w.node_value = key;
        w.parent_slot = PARENT_W'(parent);
        w.child_side = side;
        w.is_root = root;
        w.is_last = last;
        return w;
    endfunction

    // Random key in lo..hi, leaning towards the two ends. Needs lo <= hi.
    function automatic logic signed [KEY_W-1:0] pick_key(input logic signed [KEY_W-1:0] lo,
                                                         input logic signed [KEY_W-1:0] hi);
        logic [KEY_W:0]   span;
        logic [KEY_W:0]   offset;
        logic [KEY_W-1:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(7))
            0: return lo;
            1: return hi;
            default: begin
                span = {hi[KEY_W-1], hi} - {lo[KEY_W-1], lo} + 1'b1;
                offset = {1'b0, r} % span;
                return lo + offset[KEY_W-1:0];
            end
        endcase
    endfunction

    // Key outside lo..hi, mostly just past one of the bounds.
    function automatic logic signed [KEY_W-1:0] stray_key(input logic signed [KEY_W-1:0] lo,
                                                          input logic signed [KEY_W-1:0] hi);
        if (lo > hi) return {$urandom, $urandom};
        if (lo != KEY_FLOOR && (hi == KEY_LIMIT || $urandom_range(1)))
            return $urandom_range(1) ? lo - 64'sd1 : pick_key(KEY_FLOOR, lo - 64'sd1);
        if (hi != KEY_LIMIT)
            return $urandom_range(1) ? hi + 64'sd1 : pick_key(hi + 64'sd1, KEY_LIMIT);
        return {$urandom, $urandom};
    endfunction

    function automatic logic signed [KEY_W-1:0] root_key();
        case ($urandom_range(15))
            0: return KEY_FLOOR;
            1: return KEY_LIMIT;
            2: return -KEY_LIMIT;
            3: return $signed(64'($urandom_range(200))) - 64'sd100;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // A child of the open tree, or of a stale slot when flawed or orphaned.
    function automatic t_in_word make_child(input logic last, input int flaw_pct);
        logic signed [KEY_W-1:0] lo;
        logic signed [KEY_W-1:0] hi;
        logic signed [KEY_W-1:0] key;
        logic side;
        int p;
        side = $urandom_range(1);
        if (fill == 0)
            p = $urandom_range(high_water - 1);
        else if (high_water > fill && $urandom_range(99) < flaw_pct)
            p = $urandom_range(high_water - 1, fill);
        else
            p = $urandom_range(fill - 1);
        child_bounds(p, side, lo, hi);
        if ($urandom_range(99) < flaw_pct)
            key = stray_key(lo, hi);
        else if (lo <= hi)
            key = pick_key(lo, hi);
        else
            key = {$urandom, $urandom};
        return node_word(key, p, side, 1'b0, last);
    endfunction

    // Send one node word. Returns just after the accepting edge.
    task automatic send_node(input t_in_word w);
        @(negedge i_clk);
        if (!calm && $urandom_range(99) < 17) begin
            node_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        node_ch.valid <= 1'b1;
        node_ch.data <= w;
        do @(posedge i_clk); while (!node_ch.ready);
        judge_node(w);
        nodes_sent++;
    endtask

    task automatic halt_sender();
        @(negedge i_clk);
        node_ch.valid <= 1'b0;
    endtask

    // Hold the sender until every outstanding verdict has been taken.
    task automatic drain_verdicts();
        halt_sender();
        while (verdict_q.size() != 0) @(posedge i_clk);
    endtask

    // A root and size-1 children; closed trees end with a last node.
    task automatic grow_tree(input int size, input int flaw_pct, input bit closed);
        int k;
        send_node(node_word(root_key(), $urandom_range(TABLE_DEPTH - 1), $urandom_range(1),
                            1'b1, closed && size == 1));
        for (k = 1; k < size; k++)
            send_node(make_child(closed && k == size - 1, flaw_pct));
    endtask

    // One-node trees at the key extremes; the floor key is out of bounds.
    task automatic t_lone_roots();
        send_node(node_word(64'sd0, 0, SIDE_LEFT, 1'b1, 1'b1));
        send_node(node_word(KEY_LIMIT, 1023, SIDE_RIGHT, 1'b1, 1'b1));
        send_node(node_word(-KEY_LIMIT, 512, SIDE_LEFT, 1'b1, 1'b1));
        send_node(node_word(KEY_FLOOR, 341, SIDE_RIGHT, 1'b1, 1'b1));
    endtask

    // Children sitting exactly on the outer bounds, and a left child of the
    // floor key, whose upper bound saturates instead of wrapping.
    task automatic t_extreme_keys();
        send_node(node_word(64'sd0, 0, SIDE_LEFT, 1'b1, 1'b0));
        send_node(node_word(KEY_LIMIT, 0, SIDE_RIGHT, 1'b0, 1'b0));
        send_node(node_word(-KEY_LIMIT, 0, SIDE_LEFT, 1'b0, 1'b0));
        send_node(node_word(KEY_LIMIT, 1, SIDE_RIGHT, 1'b0, 1'b1));
        send_node(node_word(KEY_FLOOR, 0, SIDE_LEFT, 1'b1, 1'b0));
        send_node(node_word(KEY_FLOOR, 0, SIDE_LEFT, 1'b0, 1'b1));
    endtask

    // A root that abandons an open tree, a child with no open tree, and a
    // parent slot still holding a node of an earlier tree.
    task automatic t_tree_changes();
        send_node(node_word(64'sd5, 0, SIDE_LEFT, 1'b1, 1'b0));
        send_node(node_word(64'sd7, 0, SIDE_RIGHT, 1'b0, 1'b0));
        send_node(node_word(64'sd10, 0, SIDE_LEFT, 1'b1, 1'b0));
        send_node(node_word(64'sd3, 0, SIDE_LEFT, 1'b0, 1'b1));
        send_node(node_word(64'sd20, 0, SIDE_RIGHT, 1'b0, 1'b1));
        send_node(node_word(64'sd0, 0, SIDE_LEFT, 1'b1, 1'b0));
        send_node(node_word(KEY_LIMIT, 3, SIDE_RIGHT, 1'b0, 1'b1));
    endtask

    // Equal keys are legal on the right only; one below the bound fails.
    task automatic t_bound_violations();
        send_node(node_word(64'sd10, 0, SIDE_LEFT, 1'b1, 1'b0));
        send_node(node_word(64'sd10, 0, SIDE_LEFT, 1'b0, 1'b0));
        send_node(node_word(64'sd10, 0, SIDE_RIGHT, 1'b0, 1'b1));
        send_node(node_word(64'sd10, 0, SIDE_LEFT, 1'b1, 1'b0));
        send_node(node_word(64'sd10, 0, SIDE_RIGHT, 1'b0, 1'b1));
        send_node(node_word(-64'sd10, 0, SIDE_LEFT, 1'b1, 1'b0));
        send_node(node_word(-64'sd11, 0, SIDE_RIGHT, 1'b0, 1'b1));
    endtask

    // A well-formed tree larger than the table.
    task automatic t_full_table();
        grow_tree(TABLE_DEPTH + 2, 0, 1'b1);
    endtask

    // Mostly well-formed trees with random content, plus abandoned trees,
    // orphaned children, flawed nodes and pauses until all verdicts are in.
    task automatic t_random_forest(input int goal);
        int stop_at;
        stop_at = nodes_sent + goal;
        while (nodes_sent < stop_at) begin
            case ($urandom_range(11))
                0: begin
                    if (fill == 0 && high_water > 0)
                        send_node(make_child($urandom_range(1), 0));
                    else
                        grow_tree($urandom_range(1, 8), 10, 1'b1);
                end
                1: grow_tree($urandom_range(1, 6), 10, 1'b0);
                2: begin
                    grow_tree($urandom_range(1, 10), 10, 1'b1);
                    drain_verdicts();
                end
                3: grow_tree($urandom_range(12, 40), 5, 1'b1);
                4: grow_tree(1, 0, 1'b1);
                default: grow_tree($urandom_range(1, 12), 10, 1'b1);
            endcase
        end
    endtask

    // A stretch with neither side idling.
    task automatic t_steady_stream();
        int stop_at;
        drain_verdicts();
        calm = 1'b1;
        stop_at = nodes_sent + 120;
        while (nodes_sent < stop_at)
            grow_tree($urandom_range(1, 5), 10, 1'b1);
        calm = 1'b0;
    endtask

    initial begin
        i_rst_n = 1'b0;
        node_ch.valid = 1'b0;
        node_ch.data = '0;
        verdict_ch.ready = 1'b0;
        fill = 0;
        high_water = 0;
        tree_ok = 1'b1;
        errors = 0;
        cycles = 0;
        nodes_sent = 0;
        verdicts_checked = 0;
        broken_verdicts = 0;
        calm = 1'b0;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        t_lone_roots();
        t_extreme_keys();
        t_tree_changes();
        t_bound_violations();
        t_full_table();
        t_random_forest(250);
        t_steady_stream();
        t_random_forest(80);

        // Let the last verdicts out, then give the block time to misbehave.
        halt_sender();
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d node words, including one tree overflowing the %0d-slot table.",
                 nodes_sent, TABLE_DEPTH);
        $display("Checked %0d verdict words, %0d of them for trees that broke the ordering.",
                 verdicts_checked, broken_verdicts);
        if (errors == 0) begin
            $display("tb_bst_validity_checker passed");
        end else begin
            $display("tb_bst_validity_checker failed");
        end
        $finish;
    end

endmodule
